@@ design/corr3_pkg.sv @@
// corr3_pkg: shared types and constants of the 3x3 correlation block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package corr3_pkg;

    localparam int KDIM       = 3;
    localparam int TAPS       = KDIM * KDIM;
    localparam int ROW_BITS   = 16;
    localparam int COEF_REG_W = 48;
    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 6;

    typedef enum logic [2:0] {
        REG_FRAME_ROWS = 3'd0,
        REG_FRAME_COLS = 3'd1,
        REG_COEF_TOP   = 3'd2,
        REG_COEF_MID   = 3'd3,
        REG_COEF_BOT   = 3'd4
    } reg_idx_t;

    localparam logic [ROW_BITS-1:0]   ROWS_RESET = 16'd1024;
    localparam logic [COEF_REG_W-1:0] COEF_RESET = 48'h071C_071C_071C;

endpackage

`default_nettype wire

@@ design/correlation_3x3_clamped_border_top.sv @@
// correlation_3x3_clamped_border_top: streaming 3x3 correlation, replicated border
// depends on corr3_pkg
`timescale 1ns / 1ps
`default_nettype none

// Samples of a frame_rows x frame_cols grid enter in raster order on the s_ side, one
// transfer per cycle while s_tready is high. Each sample is read-modify-written against
// a single line memory (two rows per word, one read and one write port, registered read,
// forwarding when consecutive samples hit the same column). The 3x3 window of each sample
// that has results is queued as a job; a job releases 1 to 4 results, issued one per cycle
// while the output buffer has room, into a multiply / add / round pipeline and an 8-entry
// output buffer. Sustained rate is one sample per cycle inside a frame when the output
// does not stall; the last row releases two results per sample, so there the input is
// slowed by the single result pipeline. No clearing pass is needed after reset. Writing
// frame_rows or frame_cols restarts the frame at row 0, column 0.
module correlation_3x3_clamped_border_top
    import corr3_pkg::*;
#(
    parameter int MAX_COLS    = 1024,
    parameter int SAMPLE_BITS = 16,
    parameter int COEF_BITS   = 16
)(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // sample
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // filtered, out_row, out_col
    output logic [((SAMPLE_BITS+16+$clog2(MAX_COLS)+7)/8)*8-1:0] m_tdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic                                     m_tlast,
    // frame_done
    output logic                                     m_tuser,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [APB_ADDR_W-1:0]               paddr,
    input  wire logic [APB_DATA_W-1:0]               pwdata,
    output logic [APB_DATA_W-1:0]                    prdata,
    output logic                                     pready
);

    localparam int S     = SAMPLE_BITS;
    localparam int CW    = $clog2(MAX_COLS);
    localparam int CF    = COEF_BITS - 2;
    localparam int PW    = S + COEF_BITS;
    localparam int AW    = PW + 4;
    localparam int OW    = ((S + ROW_BITS + CW + 7) / 8) * 8;
    localparam int CEXT  = COEF_REG_W + 3 * COEF_BITS;
    localparam int JD    = 4;
    localparam int JPW   = 2;
    localparam int OD    = 8;
    localparam int OPW   = 3;
    localparam logic [CW:0] MAXC = (CW+1)'(MAX_COLS);
    localparam logic signed [AW-1:0] SAT_HI = $signed({{(AW-S+1){1'b0}}, {(S-1){1'b1}}});
    localparam logic signed [AW-1:0] SAT_LO = $signed({{(AW-S+1){1'b1}}, {(S-1){1'b0}}});
    localparam logic signed [AW-1:0] HALF   = AW'(1) <<< (CF - 1);

    // ---------------- configuration ----------------
    logic [ROW_BITS-1:0]   frame_rows_reg;
    logic [CW:0]           frame_cols_reg;
    logic [COEF_REG_W-1:0] coef_reg [KDIM];
    logic                  cfg_wr;
    reg_idx_t              cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = reg_idx_t'(paddr[5:3]);

    always_comb
    begin
        unique case (cfg_idx)
            REG_FRAME_ROWS: prdata = APB_DATA_W'(frame_rows_reg);
            REG_FRAME_COLS: prdata = APB_DATA_W'(frame_cols_reg);
            REG_COEF_TOP:   prdata = APB_DATA_W'(coef_reg[0]);
            REG_COEF_MID:   prdata = APB_DATA_W'(coef_reg[1]);
            REG_COEF_BOT:   prdata = APB_DATA_W'(coef_reg[2]);
            default:        prdata = '0;
        endcase
    end

    logic [ROW_BITS-1:0] rows_m1;
    logic [CW-1:0]       cols_m1;
    logic [CW:0]         cols_eff;

    always_comb
    begin
        rows_m1 = (frame_rows_reg == '0) ? '0 : frame_rows_reg - 1'b1;
        if (frame_cols_reg == '0)
            cols_eff = (CW+1)'(1);
        else if (frame_cols_reg > MAXC)
            cols_eff = MAXC;
        else
            cols_eff = frame_cols_reg;
        cols_m1 = CW'(cols_eff - 1'b1);
    end

    logic signed [COEF_BITS-1:0] coef [TAPS];
    logic [CEXT-1:0]             coef_ext [KDIM];

    always_comb
    begin
        for (int ki = 0; ki < KDIM; ki++)
        begin
            coef_ext[ki] = {{(3*COEF_BITS){1'b0}}, coef_reg[ki]};
            for (int kj = 0; kj < KDIM; kj++)
                coef[ki*KDIM+kj] = $signed(coef_ext[ki][kj*COEF_BITS +: COEF_BITS]);
        end
    end

    // ---------------- input side and line memory ----------------
    logic [ROW_BITS-1:0] row_cnt_reg;
    logic [CW-1:0]       col_cnt_reg;
    logic                s_acc;
    logic [ROW_BITS-1:0] r_in;
    logic [CW-1:0]       c_in;
    logic                wrap;

    logic                a_valid_reg;
    logic [ROW_BITS-1:0] a_r_reg;
    logic [CW-1:0]       a_c_reg;
    logic [S-1:0]        a_s_reg;
    logic [2*S-1:0]      mem_q_reg;
    logic                fwd_reg;
    logic [2*S-1:0]      fwd_data_reg;
    logic [2*S-1:0]      line_mem [MAX_COLS];

    logic [2:0] jcred_reg;
    logic       a_has;
    logic       j_pop;

    assign s_tready = (jcred_reg < 3'(JD));
    assign s_acc    = s_tvalid & s_tready;
    assign wrap     = ({1'b0, row_cnt_reg} > {1'b0, rows_m1}) ||
                      ({1'b0, col_cnt_reg} > {1'b0, cols_m1});
    assign r_in     = wrap ? '0 : row_cnt_reg;
    assign c_in     = wrap ? '0 : col_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_rows_reg <= ROWS_RESET;
            frame_cols_reg <= (CW+1)'(MAX_COLS);
            coef_reg[0]    <= COEF_RESET;
            coef_reg[1]    <= COEF_RESET;
            coef_reg[2]    <= COEF_RESET;
            row_cnt_reg    <= '0;
            col_cnt_reg    <= '0;
            a_valid_reg    <= 1'b0;
        end
        else
        begin
            a_valid_reg <= s_acc;
            if (cfg_wr)
            begin
                unique case (cfg_idx)
                    REG_FRAME_ROWS:
                    begin
                        frame_rows_reg <= pwdata[ROW_BITS-1:0];
                        row_cnt_reg    <= '0;
                        col_cnt_reg    <= '0;
                    end
                    REG_FRAME_COLS:
                    begin
                        frame_cols_reg <= pwdata[CW:0];
                        row_cnt_reg    <= '0;
                        col_cnt_reg    <= '0;
                    end
                    REG_COEF_TOP: coef_reg[0] <= pwdata[COEF_REG_W-1:0];
                    REG_COEF_MID: coef_reg[1] <= pwdata[COEF_REG_W-1:0];
                    REG_COEF_BOT: coef_reg[2] <= pwdata[COEF_REG_W-1:0];
                    default: ;
                endcase
            end
            else if (s_acc)
            begin
                if (c_in == cols_m1)
                begin
                    col_cnt_reg <= '0;
                    row_cnt_reg <= (r_in == rows_m1) ? '0 : r_in + 1'b1;
                end
                else
                    col_cnt_reg <= c_in + 1'b1;
            end
        end
    end

    logic [2*S-1:0] line_cur;
    logic [S-1:0]   la, lb;

    assign line_cur = fwd_reg ? fwd_data_reg : mem_q_reg;
    assign la       = line_cur[S-1:0];
    assign lb       = line_cur[2*S-1:S];

    // line word: upper half two rows above, lower half one row above
    always_ff @(posedge clk)
    begin
        if (a_valid_reg)
            line_mem[a_c_reg] <= {la, a_s_reg};
        if (s_acc)
        begin
            mem_q_reg    <= line_mem[c_in];
            fwd_reg      <= a_valid_reg && (a_c_reg == c_in);
            fwd_data_reg <= {la, a_s_reg};
            a_r_reg      <= r_in;
            a_c_reg      <= c_in;
            a_s_reg      <= s_tdata[S-1:0];
        end
    end

    // ---------------- window and job queue ----------------
    logic [S-1:0] win_reg [TAPS];
    logic [S-1:0] win_new [TAPS];
    logic         f_r0, f_r1, f_c0, f_c1;

    always_comb
    begin
        for (int k = 0; k < KDIM; k++)
        begin
            win_new[k*KDIM+0] = win_reg[k*KDIM+1];
            win_new[k*KDIM+1] = win_reg[k*KDIM+2];
        end
        win_new[2]   = lb;
        win_new[5]   = la;
        win_new[8]   = a_s_reg;
        f_r0  = (a_r_reg != '0);
        f_r1  = (a_r_reg == rows_m1);
        f_c0  = (a_c_reg != '0);
        f_c1  = (a_c_reg == cols_m1);
        a_has = (f_r0 | f_r1) & (f_c0 | f_c1);
    end

    logic [S-1:0]        job_win [JD][TAPS];
    logic [ROW_BITS-1:0] job_r   [JD];
    logic [CW-1:0]       job_c   [JD];
    logic [3:0]          job_f   [JD];
    logic [JPW-1:0]      jwr_reg, jrd_reg;
    logic [JPW:0]        jocc_reg;
    logic                j_push;

    assign j_push = a_valid_reg & a_has;

    always_ff @(posedge clk)
    begin
        if (a_valid_reg)
            win_reg <= win_new;
        if (j_push)
        begin
            job_win[jwr_reg] <= win_new;
            job_r[jwr_reg]   <= a_r_reg;
            job_c[jwr_reg]   <= a_c_reg;
            job_f[jwr_reg]   <= {f_c1, f_c0, f_r1, f_r0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            jwr_reg   <= '0;
            jrd_reg   <= '0;
            jocc_reg  <= '0;
            jcred_reg <= '0;
        end
        else
        begin
            if (j_push)
                jwr_reg <= jwr_reg + 1'b1;
            if (j_pop)
                jrd_reg <= jrd_reg + 1'b1;
            jocc_reg  <= jocc_reg + (JPW+1)'(j_push) - (JPW+1)'(j_pop);
            jcred_reg <= jcred_reg + 3'(s_acc) - 3'(a_valid_reg & ~a_has) - 3'(j_pop);
        end
    end

    // ---------------- result issue ----------------
    function automatic logic [1:0] tap_idx(input logic [ROW_BITS-1:0] pos,
                                           input int k,
                                           input logic [ROW_BITS-1:0] last,
                                           input logic [ROW_BITS-1:0] base);
        logic signed [ROW_BITS+1:0] d;
        logic signed [ROW_BITS+1:0] w;
        d = $signed({2'b00, pos}) + (ROW_BITS+2)'(k) - (ROW_BITS+2)'(1);
        if (d < 0)
            d = '0;
        if (d > $signed({2'b00, last}))
            d = $signed({2'b00, last});
        w = d - $signed({2'b00, base}) + (ROW_BITS+2)'(2);
        return w[1:0];
    endfunction

    logic [3:0]          ocred_reg;
    logic                ri_reg, ci_reg;
    logic                issue;
    logic [3:0]          hf;
    logic [ROW_BITS-1:0] hr, cur_r;
    logic [CW-1:0]       hc, cur_c;
    logic                row_end, col_end;
    logic [S-1:0]        tap_next [TAPS];
    logic [1:0]          wr_i, wc_i;

    always_comb
    begin
        hf    = job_f[jrd_reg];
        hr    = job_r[jrd_reg];
        hc    = job_c[jrd_reg];
        issue = (jocc_reg != '0) && (ocred_reg < 4'(OD));
        cur_r = (hf[0] && !ri_reg) ? hr - 1'b1 : hr;
        cur_c = (hf[2] && !ci_reg) ? hc - 1'b1 : hc;
        // second row or column exists only when both flags are set
        row_end = ri_reg || !(hf[0] && hf[1]);
        col_end = ci_reg || !(hf[2] && hf[3]);
        j_pop   = issue & row_end & col_end;
        for (int ki = 0; ki < KDIM; ki++)
        begin
            for (int kj = 0; kj < KDIM; kj++)
            begin
                wr_i = tap_idx(cur_r, ki, rows_m1, hr);
                wc_i = tap_idx(ROW_BITS'(cur_c), kj, ROW_BITS'(cols_m1), ROW_BITS'(hc));
                if (wr_i == 2'd3 || wc_i == 2'd3)
                    tap_next[ki*KDIM+kj] = '0;
                else
                    tap_next[ki*KDIM+kj] = job_win[jrd_reg][wr_i*KDIM + wc_i];
            end
        end
    end

    logic                p1_valid_reg, p2_valid_reg, p3_valid_reg;
    logic [S-1:0]        p1_tap_reg [TAPS];
    logic signed [PW-1:0] p2_prod_reg [TAPS];
    logic signed [AW-1:0] p3_sum_reg [KDIM];
    logic [ROW_BITS-1:0] p1_row_reg, p2_row_reg, p3_row_reg;
    logic [CW-1:0]       p1_col_reg, p2_col_reg, p3_col_reg;
    logic                p1_last_reg, p2_last_reg, p3_last_reg;
    logic                p1_done_reg, p2_done_reg, p3_done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ri_reg       <= 1'b0;
            ci_reg       <= 1'b0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= issue;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            if (issue)
            begin
                if (col_end)
                begin
                    ci_reg <= 1'b0;
                    ri_reg <= row_end ? 1'b0 : 1'b1;
                end
                else
                    ci_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        p1_tap_reg  <= tap_next;
        p1_row_reg  <= cur_r;
        p1_col_reg  <= cur_c;
        p1_last_reg <= row_end & col_end;
        p1_done_reg <= (cur_r == rows_m1) && (cur_c == cols_m1);
        for (int t = 0; t < TAPS; t++)
            p2_prod_reg[t] <= $signed(p1_tap_reg[t]) * coef[t];
        p2_row_reg  <= p1_row_reg;
        p2_col_reg  <= p1_col_reg;
        p2_last_reg <= p1_last_reg;
        p2_done_reg <= p1_done_reg;
        for (int k = 0; k < KDIM; k++)
            p3_sum_reg[k] <= AW'(p2_prod_reg[k*KDIM]) + AW'(p2_prod_reg[k*KDIM+1])
                           + AW'(p2_prod_reg[k*KDIM+2]);
        p3_row_reg  <= p2_row_reg;
        p3_col_reg  <= p2_col_reg;
        p3_last_reg <= p2_last_reg;
        p3_done_reg <= p2_done_reg;
    end

    // round half up, then saturate
    logic signed [AW-1:0] total, rnd;
    logic [S-1:0]         filt;

    always_comb
    begin
        total = p3_sum_reg[0] + p3_sum_reg[1] + p3_sum_reg[2];
        rnd   = (total + HALF) >>> CF;
        if (rnd > SAT_HI)
            filt = SAT_HI[S-1:0];
        else if (rnd < SAT_LO)
            filt = SAT_LO[S-1:0];
        else
            filt = rnd[S-1:0];
    end

    // ---------------- output buffer ----------------
    logic [S-1:0]        ob_filt [OD];
    logic [ROW_BITS-1:0] ob_row  [OD];
    logic [CW-1:0]       ob_col  [OD];
    logic                ob_last [OD];
    logic                ob_done [OD];
    logic [OPW-1:0]      owr_reg, ord_reg;
    logic [OPW:0]        oocc_reg;
    logic                m_acc;

    assign m_tvalid = (oocc_reg != '0);
    assign m_acc    = m_tvalid & m_tready;
    assign m_tdata  = OW'({ob_col[ord_reg], ob_row[ord_reg], ob_filt[ord_reg]});
    assign m_tlast  = ob_last[ord_reg];
    assign m_tuser  = ob_done[ord_reg];

    always_ff @(posedge clk)
    begin
        if (p3_valid_reg)
        begin
            ob_filt[owr_reg] <= filt;
            ob_row[owr_reg]  <= p3_row_reg;
            ob_col[owr_reg]  <= p3_col_reg;
            ob_last[owr_reg] <= p3_last_reg;
            ob_done[owr_reg] <= p3_done_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owr_reg   <= '0;
            ord_reg   <= '0;
            oocc_reg  <= '0;
            ocred_reg <= '0;
        end
        else
        begin
            if (p3_valid_reg)
                owr_reg <= owr_reg + 1'b1;
            if (m_acc)
                ord_reg <= ord_reg + 1'b1;
            oocc_reg  <= oocc_reg + (OPW+1)'(p3_valid_reg) - (OPW+1)'(m_acc);
            ocred_reg <= ocred_reg + 4'(issue) - 4'(m_acc);
        end
    end

endmodule

`default_nettype wire
